// ----- sv/smma_pkg.sv -----
package smma_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_ISSUE,
    ST_DRAIN
  } smma_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;         // store the accepted word pair
    logic rd;         // read one term pair
    logic sum;        // term is a + b instead of a * b
    logic first;      // first term of a result element
    logic last_term;  // final term of a result element
    logic last_elem;  // element is the final one of C
  } smma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;   // output register holds a word not yet taken
    logic done;       // output register loads a finished element this cycle
  } smma_stat_t;

endpackage

// ----- sv/smma_ram.sv -----
module smma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/smma_ctrl.sv -----
module smma_ctrl #(
  parameter int DIM = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  smma_pkg::smma_stat_t     stat,
  output smma_pkg::smma_cmd_t      cmd,
  output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] wr_addr,
  output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_a_addr,
  output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_b_addr
);
  import smma_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;

  smma_state_t   state, state_next;
  logic [AW-1:0] load_count;
  logic [IW-1:0] row, col, k;
  logic          op_mode;
  logic          run_sum;
  logic          load_last, k_last, elem_last, accept;

  assign accept    = (state == ST_LOAD) && in_valid;
  assign load_last = (load_count == AW'(CELLS - 1));
  assign k_last    = run_sum || (k == IW'(DIM - 1));
  assign elem_last = (row == IW'(DIM - 1)) && (col == IW'(DIM - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (accept && load_last) state_next = ST_WAIT;
      ST_WAIT:  if (!stat.out_busy) state_next = ST_ISSUE;
      ST_ISSUE: if (k_last) state_next = ST_DRAIN;
      ST_DRAIN: if (stat.done) state_next = elem_last ? ST_LOAD : ST_WAIT;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_LOAD);
    cmd.wr        = accept;
    cmd.rd        = (state == ST_ISSUE);
    cmd.sum       = run_sum;
    cmd.first     = (k == '0);
    cmd.last_term = k_last;
    cmd.last_elem = elem_last;
    wr_addr       = load_count;
    if (run_sum) begin
      rd_a_addr = AW'(int'(row) * DIM + int'(col));
      rd_b_addr = AW'(int'(row) * DIM + int'(col));
    end else begin
      rd_a_addr = AW'(int'(row) * DIM + int'(k));
      rd_b_addr = AW'(int'(k) * DIM + int'(col));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
      op_mode    <= 1'b1;
      run_sum    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        op_mode <= cfg_wr_data;
      end
      if (accept) begin
        if (load_last) begin
          load_count <= '0;
          run_sum    <= ~op_mode;
        end else begin
          load_count <= load_count + AW'(1);
        end
      end
      if (state == ST_ISSUE) begin
        k <= k_last ? '0 : k + IW'(1);
      end
      if ((state == ST_DRAIN) && stat.done) begin
        if (col == IW'(DIM - 1)) begin
          col <= '0;
          row <= elem_last ? '0 : row + IW'(1);
        end else begin
          col <= col + IW'(1);
        end
      end
    end
  end

endmodule

// ----- sv/smma_dp.sv -----
module smma_dp #(
  parameter int DIM = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smma_pkg::smma_cmd_t                  cmd,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] wr_addr,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_a_addr,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_b_addr,
  output smma_pkg::smma_stat_t                 stat,
  input  logic signed [smma_pkg::DATA_W-1:0]   a_value,
  input  logic signed [smma_pkg::DATA_W-1:0]   b_value,
  output logic signed [smma_pkg::DATA_W-1:0]   c_value,
  output logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall
);
  import smma_pkg::*;

  localparam int CELLS = DIM * DIM;

  logic [DATA_W-1:0] a_rd, b_rd;
  logic [DATA_W-1:0] term_w, prod, acc, acc_next;
  logic              s1_v, s1_sum, s1_first, s1_last_term, s1_last_elem;
  logic              s2_v, s2_first, s2_last_term, s2_last_elem;
  logic              finish;

  smma_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata (a_value),
    .raddr (rd_a_addr),
    .rdata (a_rd)
  );

  smma_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata (b_value),
    .raddr (rd_b_addr),
    .rdata (b_rd)
  );

  // low word of the product is the same for signed and unsigned operands
  assign term_w   = s1_sum ? (a_rd + b_rd) : (a_rd * b_rd);
  assign acc_next = s2_first ? prod : (acc + prod);
  assign finish   = s2_v && s2_last_term;

  assign stat.out_busy = out_valid;
  assign stat.done     = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= cmd.rd;
      s2_v <= s1_v;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_sum       <= cmd.sum;
    s1_first     <= cmd.first;
    s1_last_term <= cmd.last_term;
    s1_last_elem <= cmd.last_elem;
    prod         <= term_w;
    s2_first     <= s1_first;
    s2_last_term <= s1_last_term;
    s2_last_elem <= s1_last_elem;
    if (s2_v) begin
      acc <= acc_next;
    end
    if (finish) begin
      c_value <= acc_next;
      last    <= s2_last_elem;
    end
  end

endmodule

// ----- sv/small_matrix_multiply_add_core.sv -----
// Square integer matrix sum or product. Feed DIM*DIM input words, each
// carrying one element of A and the element of B at the same position,
// in row-major order; one word is taken per cycle while loading. The
// word that completes the matrices starts the result phase and samples
// op_mode (1 = matrix product, 0 = element-wise sum; reset 1). The block
// then sends the DIM*DIM elements of C in row-major order, wrapped to
// 32 bits, with last set on the final one, and stalls its input until
// that final word sits in the output register. Each product element issues
// DIM term reads through the single read port of each element store,
// then passes the registered read, the multiplier register and the
// accumulator, and one more state waits to see the output register free.
// A sum element issues a single term read. The final element of a pass
// skips that last wait, since loading reopens as soon as its word is
// registered. Loading of the next pass may begin while the final result
// word still waits.
module small_matrix_multiply_add_core #(
  parameter int DIM = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [smma_pkg::DATA_W-1:0] a_value,
  input  logic signed [smma_pkg::DATA_W-1:0] b_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [smma_pkg::DATA_W-1:0] c_value,
  output logic                               last
);
  import smma_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  smma_cmd_t     cmd;
  smma_stat_t    stat;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

  // Sequence loads, term reads and element hand-off.
  smma_ctrl #(.DIM(DIM)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (rd_b_addr)
  );

  // Hold both matrices, form terms, accumulate and drive the output word.
  smma_dp #(.DIM(DIM)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .stat      (stat),
    .a_value   (a_value),
    .b_value   (b_value),
    .c_value   (c_value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

// ----- sv/smma_checker.sv -----
module smma_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [smma_pkg::DATA_W-1:0] c_value,
  input logic                               last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(c_value) && $stable(last))
    else $error("stalled output word changed");

  // reset leaves the block ready to load with nothing to send
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // while an element other than the final one waits, input stays stalled
  a_stall_mid_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input open during result phase");

  // a new element is only issued once the output register is free, so words never come back to back
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result words back to back");

endmodule

bind small_matrix_multiply_add_core smma_checker u_smma_checker (.*);

// ----- dv/smma_checker.sv -----
package smma_tb_pkg;

  typedef enum logic {
    MODE_SUM     = 1'b0,
    MODE_PRODUCT = 1'b1
  } smma_mode_t;

endpackage

module smma_result_checker #(
  parameter int DIM = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [smma_pkg::DATA_W-1:0]  a_value,
  input  logic [smma_pkg::DATA_W-1:0]  b_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [smma_pkg::DATA_W-1:0]  c_value,
  input  logic                         last,
  output int                           mismatches,
  output int                           pending
);

  import smma_tb_pkg::*;

  localparam int W     = smma_pkg::DATA_W;
  localparam int CELLS = DIM * DIM;

  typedef struct packed {
    logic [W-1:0] c;
    logic         last;
  } c_word_t;

  smma_mode_t   mode;
  logic [W-1:0] a_cells [CELLS];
  logic [W-1:0] b_cells [CELLS];
  int           fill;
  c_word_t      c_due [$];

  // store one A/B pair; on the final pair of a pass, queue the whole of C
  task automatic take_pair(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] acc;
    c_word_t      word;
    a_cells[fill] = a;
    b_cells[fill] = b;
    fill++;
    if (fill == CELLS) begin
      fill = 0;
      for (int row = 0; row < DIM; row++) begin
        for (int col = 0; col < DIM; col++) begin
          if (mode == MODE_SUM) begin
            acc = a_cells[row*DIM+col] + b_cells[row*DIM+col];
          end else begin
            acc = '0;
            // 32-bit context keeps only the low word of each product
            for (int k = 0; k < DIM; k++)
              acc = acc + a_cells[row*DIM+k] * b_cells[k*DIM+col];
          end
          word.c    = acc;
          word.last = (row == DIM-1) && (col == DIM-1);
          c_due.push_back(word);
        end
      end
    end
  endtask

  task automatic check_word(input logic [W-1:0] c_got, input logic last_got);
    c_word_t want;
    if (c_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: c_value=%h last=%b", c_got, last_got);
    end else begin
      want = c_due.pop_front();
      if (c_got !== want.c || last_got !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected c_value=%h last=%b, got c_value=%h last=%b",
                   want.c, want.last, c_got, last_got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode       = MODE_PRODUCT;
      fill       = 0;
      mismatches = 0;
      c_due.delete();
    end else begin
      if (cfg_wr_en)
        mode = smma_mode_t'(cfg_wr_data);
      // check before taking, so a word cannot match what this edge just queued
      if (out_valid && !out_stall)
        check_word(c_value, last);
      if (in_valid && !in_stall)
        take_pair(a_value, b_value);
    end
    pending = c_due.size();
  end

endmodule

// ----- dv/tb_small_matrix_multiply_add_core.sv -----
module tb_small_matrix_multiply_add_core;

  import smma_tb_pkg::*;

  localparam int DIM            = 3;
  localparam int W              = smma_pkg::DATA_W;
  localparam int RANDOM_PAIRS   = 320;
  // leave ample room after the last word
  localparam int SETTLE_CYCLES  = 4 * (DIM + 4) + 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic signed [W-1:0] a_value     = '0;
  logic signed [W-1:0] b_value     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic signed [W-1:0] c_value;
  logic                last;

  int   mismatches;
  int   pending;
  int   pairs_sent    = 0;
  int   quiet_cycles  = 0;
  logic sender_calm   = 1'b0;
  logic receiver_calm = 1'b0;
  logic hold_req      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  small_matrix_multiply_add_core #(
    .DIM(DIM)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .a_value    (a_value),
    .b_value    (b_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .c_value    (c_value),
    .last       (last)
  );

  smma_result_checker #(
    .DIM(DIM)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .a_value    (a_value),
    .b_value    (b_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .c_value    (c_value),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Mix of full-range random words and the corners: most negative, most
  // positive, zero, minus one and small signed values.
  function automatic logic [W-1:0] rand_word();
    unique case ($urandom_range(0, 9))
      5:       return 32'h8000_0000;
      6:       return 32'h7FFF_FFFF;
      7:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      8:       return $urandom_range(0, 15) - 8;
      9:       return $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFE;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap, then hold it until the block takes it.
  // When there is no gap, valid stays high and only the payload advances.
  task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (sender_calm || pick < 60)
      gap = 0;
    else if (pick < 90)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    a_value  <= a;
    b_value  <= b;
    do @(posedge clk); while (in_stall);
    pairs_sent++;
  endtask

  // Drop valid, wait for every predicted result word, then let the block
  // finish anything a partial load might still have in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input smma_mode_t mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: runs of stall and no stall of random length, mostly short.
  // A hold request from the stimulus turns into one long stall, counted
  // here, while the sender keeps offering words so the block backs up.
  initial begin : drain_side
    int   run_left;
    logic stall_now;
    logic hold_done;
    run_left  = 0;
    stall_now = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        stall_now = 1'b0;
        run_left  = 0;
      end else if (receiver_calm) begin
        out_stall <= 1'b0;
        stall_now = 1'b0;
        run_left  = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < 35);
          if (!stall_now)
            run_left = $urandom_range(1, 8);
          else if ($urandom_range(0, 99) < 85)
            run_left = $urandom_range(1, 3);
          else
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        out_stall <= stall_now;
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int burst;
    int phase;
    logic both_calm;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Write the register once straight after reset; product is also its reset value.
    write_mode(MODE_PRODUCT);

    // Product pass over the extremes: min and max words, minus one, zero, one.
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'h0000_0000);
    send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h0000_0002, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'h0000_0003);

    // Start the next pass, switch to sum partway through the load: the mode
    // is taken only on the word that completes the matrices.
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h0000_0001);
    settle();
    write_mode(MODE_SUM);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001);
    send_pair(32'h1234_5678, 32'hEDCB_A988);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases: each picks a mode and a burst length that rarely lines
    // up with a pass, so mode writes also land in the middle of loads.
    phase = 0;
    while (pairs_sent < RANDOM_PAIRS) begin
      settle();
      write_mode(smma_mode_t'($urandom_range(0, 1)));
      both_calm     = ($urandom_range(0, 4) == 0);
      sender_calm   = both_calm;
      receiver_calm = both_calm;
      burst         = $urandom_range(4, 45);
      if (phase == 2) begin
        // back-to-back words against a long receiver hold-off
        sender_calm = 1'b1;
        hold_req    = 1'b1;
        burst       = 36;
      end
      repeat (burst) send_pair(rand_word(), rand_word());
      phase++;
    end

    settle();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
